/* design/lwgc_pkg.sv */
package lwgc_pkg;

    localparam int ONE_Q = 256;
    localparam int CAP_Q = 1024;
    localparam int CNT_W = 12;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_HIT_GAP,
        ST_HIT_UPD,
        ST_FILL,
        ST_SW_GAP,
        ST_SW_UPD,
        ST_NEW_GAP,
        ST_NEW_UPD,
        ST_DONE
    } lwgc_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch request word
        logic scan_start;  // start a pass over all slots
        logic gap_mode;    // pass computes a gap, else searches for the page
        logic hit_upd;     // apply hit weight
        logic sweep_upd;   // lower count at the hand
        logic hand_step;   // advance the hand
        logic place;       // write new page at the hand
        logic new_upd;     // set count of the new page
        logic fill_note;   // record a cold miss
        logic warm_note;   // record warm flag
        logic out_load;    // register result
    } lwgc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic warm;
        logic count_pos;
        logic sweep_over;
    } lwgc_sts_t;

endpackage

/* design/lwgc_ctrl.sv */
module lwgc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              out_busy,
    input  lwgc_pkg::lwgc_sts_t sts,
    output lwgc_pkg::lwgc_cmd_t cmd
);
    import lwgc_pkg::*;

    lwgc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cmd.warm_note = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (sts.scan_done) begin
                    if (sts.found) begin
                        cmd.scan_start = 1'b1;
                        cmd.gap_mode = 1'b1;
                        state_next = ST_HIT_GAP;
                    end else if (!sts.warm) begin
                        state_next = ST_FILL;
                    end else begin
                        cmd.scan_start = 1'b1;
                        cmd.gap_mode = 1'b1;
                        state_next = ST_SW_GAP;
                    end
                end
            end
            ST_HIT_GAP: begin
                cmd.gap_mode = 1'b1;
                if (sts.scan_done) state_next = ST_HIT_UPD;
            end
            ST_HIT_UPD: begin
                cmd.hit_upd = 1'b1;
                state_next = ST_DONE;
            end
            ST_FILL: begin
                cmd.fill_note = 1'b1;
                cmd.place = 1'b1;
                cmd.scan_start = 1'b1;
                cmd.gap_mode = 1'b1;
                state_next = ST_NEW_GAP;
            end
            ST_SW_GAP: begin
                cmd.gap_mode = 1'b1;
                if (sts.scan_done) state_next = ST_SW_UPD;
            end
            ST_SW_UPD: begin
                cmd.sweep_upd = 1'b1;
                state_next = ST_SW_UPD;
                if (sts.count_pos && !sts.sweep_over) begin
                    cmd.hand_step = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.gap_mode = 1'b1;
                    state_next = ST_SW_GAP;
                end else begin
                    cmd.sweep_upd = 1'b0;
                    cmd.place = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.gap_mode = 1'b1;
                    state_next = ST_NEW_GAP;
                end
            end
            ST_NEW_GAP: begin
                cmd.gap_mode = 1'b1;
                if (sts.scan_done) state_next = ST_NEW_UPD;
            end
            ST_NEW_UPD: begin
                cmd.new_upd = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* design/lwgc_dp.sv */
module lwgc_dp #(
    parameter int SLOTS = 64,
    parameter int PAGE_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [5:0]             cfg_wdata,
    input  logic                   cfg_we,
    input  logic [PAGE_BITS-1:0]   s_page_id,
    input  lwgc_pkg::lwgc_cmd_t    cmd,
    output lwgc_pkg::lwgc_sts_t    sts,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic                   m_hit,
    output logic                   m_warm,
    output logic                   m_victim_valid,
    output logic [23:0]            m_victim_page,
    output logic [5:0]             m_slot,
    output logic                   out_busy
);
    import lwgc_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 1);
    localparam int VW = $clog2(SLOTS * 8 + 2);

    logic [5:0]            md_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic [SW-1:0]         hand_reg, tgt_reg, scan_reg, hit_slot_reg, cmp_idx_reg;
    logic [FW-1:0]         filled_reg;
    logic                  scanning_reg, cmp_vld_reg, fetch_reg, found_reg, warm_reg;
    logic                  any_reg;
    logic [PAGE_BITS-1:0]  best_reg, gp_reg;
    logic [VW-1:0]         visit_reg;
    logic                  vvalid_reg;
    logic [PAGE_BITS-1:0]  vpage_reg;
    logic [8:0]            frac_reg;

    // gap pass target: hit slot or hand
    logic [SW-1:0]         gap_slot, hand_inc, tgt_sel, pg_raddr;
    logic [PAGE_BITS-1:0]  pg_rdata, qp, gdiff;
    logic                  skip, issue_last, cmp_last;
    assign gap_slot = found_reg ? hit_slot_reg : hand_reg;
    assign hand_inc = (hand_reg == SW'(SLOTS - 1)) ? '0 : hand_reg + 1'b1;
    assign tgt_sel = cmd.place ? hand_reg : (cmd.hand_step ? hand_inc : gap_slot);
    // page word arrives in the cycle after its address; idle reads sit on the hand
    assign pg_raddr = cmd.scan_start ? tgt_sel : (scanning_reg ? scan_reg : hand_reg);
    assign qp = pg_rdata;
    assign gdiff = (qp > gp_reg) ? qp - gp_reg : gp_reg - qp;
    assign skip = (cmp_idx_reg == tgt_reg) || !valid_reg[cmp_idx_reg];
    assign issue_last = (scan_reg == SW'(SLOTS - 1));
    assign cmp_last = (cmp_idx_reg == SW'(SLOTS - 1));

    lwgc_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOTS), .ADDR_W(SW)) u_page_ram (
        .aclk(aclk), .we(cmd.place), .waddr(hand_reg), .wdata(page_reg),
        .raddr(pg_raddr), .rdata(pg_rdata)
    );

    // fraction: (d*256 + md/2) / md, d <= 63, by restoring division
    logic [5:0]  md_eff, dcl;
    logic [PAGE_BITS-1:0] gap_v;
    assign md_eff = (md_reg == 6'd0) ? 6'd1 : md_reg;
    assign gap_v = any_reg ? best_reg : '0;
    assign dcl = (gap_v > PAGE_BITS'(md_eff)) ? md_eff : gap_v[5:0];

    logic [14:0] num, rem;
    logic [8:0]  quo;
    logic        div_go_reg;
    logic [3:0]  div_cnt_reg;
    logic [14:0] rem_reg;
    logic [8:0]  quo_reg;
    assign num = {1'b0, dcl, 8'd0} + 15'(md_eff >> 1);

    logic [CNT_W-1:0]        cnt_rdata, cnt_wdata;
    logic                    cnt_we;
    logic signed [CNT_W-1:0] cur, wgt, frq, sum;
    assign cur = cnt_rdata;
    assign frq = CNT_W'(frac_reg);
    assign wgt = CNT_W'(ONE_Q) - frq;
    assign sum = cur + wgt;
    logic signed [CNT_W-1:0] dec, lowered;
    assign dec = (visit_reg >= VW'(SLOTS)) ? CNT_W'(ONE_Q) : frq;
    assign lowered = cur - dec;

    // counts are only read for resident slots, each set after its page is placed
    assign cnt_we = (cmd.hit_upd && sum <= CNT_W'(CAP_Q)) || cmd.sweep_upd || cmd.new_upd;
    assign cnt_wdata = cmd.hit_upd ? sum : (cmd.sweep_upd ? lowered : wgt);

    lwgc_ram #(.WIDTH(CNT_W), .DEPTH(SLOTS), .ADDR_W(SW)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(gap_slot), .wdata(cnt_wdata),
        .raddr(gap_slot), .rdata(cnt_rdata)
    );

    logic obuf_reg;
    assign out_busy = obuf_reg && !m_ready;
    assign m_valid = obuf_reg;

    always_comb begin
        sts.scan_done = !scanning_reg && !cmp_vld_reg && !div_go_reg;
        sts.found = found_reg;
        sts.warm = warm_reg;
        sts.count_pos = lowered > 0;
        sts.sweep_over = visit_reg >= VW'(SLOTS * 8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            md_reg <= 6'd6;
            valid_reg <= '0;
            hand_reg <= '0;
            filled_reg <= '0;
            scanning_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            fetch_reg <= 1'b0;
            found_reg <= 1'b0;
            div_go_reg <= 1'b0;
            obuf_reg <= 1'b0;
        end else begin
            if (cfg_we) md_reg <= cfg_wdata;
            if (cmd.load) begin
                page_reg <= s_page_id;
                found_reg <= 1'b0;
                vvalid_reg <= 1'b0;
                vpage_reg <= '0;
                visit_reg <= '0;
            end
            if (cmd.warm_note) warm_reg <= (filled_reg >= FW'(SLOTS));
            // the sweep target page is fetched, a hit or new page is the request
            fetch_reg <= cmd.scan_start && cmd.gap_mode && !cmd.place && !found_reg;
            cmp_vld_reg <= scanning_reg;
            cmp_idx_reg <= scan_reg;
            if (cmd.scan_start) begin
                scanning_reg <= 1'b1;
                scan_reg <= '0;
                any_reg <= 1'b0;
                tgt_reg <= tgt_sel;
                gp_reg <= page_reg;
            end else begin
                if (fetch_reg) gp_reg <= pg_rdata;
                if (scanning_reg) begin
                    scan_reg <= scan_reg + 1'b1;
                    if (issue_last) scanning_reg <= 1'b0;
                end
                if (cmp_vld_reg) begin
                    if (cmd.gap_mode) begin
                        if (!skip && (!any_reg || gdiff < best_reg)) begin
                            best_reg <= gdiff;
                            any_reg <= 1'b1;
                        end
                    end else if (valid_reg[cmp_idx_reg] && qp == page_reg && !found_reg) begin
                        found_reg <= 1'b1;
                        hit_slot_reg <= cmp_idx_reg;
                    end
                    if (cmp_last && cmd.gap_mode) begin
                        div_go_reg <= 1'b1;
                        div_cnt_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                    end
                end else if (div_go_reg) begin
                    // one quotient bit per cycle, msb first over 15 numerator bits
                    rem_reg <= rem;
                    quo_reg <= quo;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 4'd14) begin
                        div_go_reg <= 1'b0;
                        frac_reg <= quo;
                    end
                end
            end
            if (cmd.sweep_upd) visit_reg <= visit_reg + 1'b1;
            if ((cmd.sweep_upd && cmd.hand_step) || cmd.new_upd) hand_reg <= hand_inc;
            if (cmd.place) begin
                vvalid_reg <= valid_reg[hand_reg];
                vpage_reg <= valid_reg[hand_reg] ? pg_rdata : '0;
                valid_reg[hand_reg] <= 1'b1;
                hit_slot_reg <= hand_reg;
            end
            if (cmd.fill_note) filled_reg <= filled_reg + 1'b1;
            if (cmd.out_load) begin
                obuf_reg <= 1'b1;
                m_hit <= found_reg;
                m_warm <= warm_reg;
                m_victim_valid <= vvalid_reg;
                m_victim_page <= 24'(vpage_reg);
                m_slot <= 6'(hit_slot_reg);
            end else if (m_ready) begin
                obuf_reg <= 1'b0;
            end
        end
    end

    // restoring divide step
    logic [14:0] rsh;
    always_comb begin
        rsh = {rem_reg[13:0], num[4'd14 - div_cnt_reg]};
        if (rsh >= 15'(md_eff)) begin
            rem = rsh - 15'(md_eff);
            quo = {quo_reg[7:0], 1'b1};
        end else begin
            rem = rsh;
            quo = {quo_reg[7:0], 1'b0};
        end
    end

endmodule

module lwgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

/* design/locality_weighted_gclock_replacer_core.sv */
// Locality-weighted generalized-clock page replacer. One request word at a
// time: the page is searched over all slots, and each locality fraction
// needs a pass over the page store, a serial divide and a decision state.
// A hit takes the search and one fraction, a cold miss a fill step and one
// fraction, and a warm miss one fraction per slot visited by the hand (at
// most SLOTS*8+1) and one for the new page. A result still waiting on
// m_ready holds the next word back. The user must write max_distance through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module locality_weighted_gclock_replacer_core #(
    parameter int SLOTS = 64,
    parameter int PAGE_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [5:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PAGE_BITS-1:0] s_page_id,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic                 m_warm,
    output logic                 m_victim_valid,
    output logic [23:0]          m_victim_page,
    output logic [5:0]           m_slot
);
    import lwgc_pkg::*;

    lwgc_cmd_t cmd;
    lwgc_sts_t sts;
    logic      out_busy;

    lwgc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .out_busy(out_busy), .sts(sts), .cmd(cmd)
    );

    lwgc_dp #(.SLOTS(SLOTS), .PAGE_BITS(PAGE_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_wdata(cfg_wdata), .cfg_we(cfg_we),
        .s_page_id(s_page_id), .cmd(cmd), .sts(sts), .m_ready(m_ready),
        .m_valid(m_valid), .m_hit(m_hit), .m_warm(m_warm),
        .m_victim_valid(m_victim_valid), .m_victim_page(m_victim_page),
        .m_slot(m_slot), .out_busy(out_busy)
    );

endmodule
